// ===== design/assert_macros.svh =====
// Assertion macros shared by the deframer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, quiet while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check that a condition never holds.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== design/irdf_pkg.sv =====
// Types and constants shared by the interleaved RTP deframer modules.
package irdf_pkg;

    localparam logic [7:0]  SYNC_BYTE     = 8'h24;
    localparam logic [23:0] RTP_HDR_BYTES = 24'd12;

    // Header position codes.
    localparam logic [4:0] POS_HUNT      = 5'd0;
    localparam logic [4:0] POS_CHANNEL   = 5'd1;
    localparam logic [4:0] POS_LEN_FIRST = 5'd4;
    localparam logic [4:0] POS_LEN_LAST  = 5'd7;
    localparam logic [4:0] POS_RTP_FIRST = 5'd8;
    localparam logic [4:0] POS_RTP_LAST  = 5'd19;
    localparam logic [4:0] POS_PAYLOAD   = 5'd20;
    localparam logic [4:0] POS_DROP      = 5'd21;
    localparam logic [4:0] POS_EXPECT    = 5'd22;

    // Offsets inside the RTP header.
    localparam logic [4:0] RTP_TYPE_OFS        = 5'd1;
    localparam logic [4:0] RTP_STAMP_FIRST_OFS = 5'd4;
    localparam logic [4:0] RTP_STAMP_LAST_OFS  = 5'd7;

    // Configuration register indexes.
    localparam logic [1:0] REG_MAX_LEN    = 2'd0;
    localparam logic [1:0] REG_VIDEO_TYPE = 2'd1;
    localparam logic [1:0] REG_AUDIO_TYPE = 2'd2;
    localparam logic [1:0] REG_AUDIO_SKIP = 2'd3;

    localparam logic [23:0] RST_MAX_LEN    = 24'd2764800;
    localparam logic [6:0]  RST_VIDEO_TYPE = 7'd96;
    localparam logic [6:0]  RST_AUDIO_TYPE = 7'd97;
    localparam logic [3:0]  RST_AUDIO_SKIP = 4'd4;

    localparam logic KIND_VIDEO = 1'b0;
    localparam logic KIND_AUDIO = 1'b1;

    typedef enum logic [1:0] {
        ST_DATA   = 2'd0,
        ST_REJECT = 2'd1,
        ST_SHORT  = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       stream_kind;
        logic [7:0] channel_id;
        logic       frame_start;
        logic       packet_last;
        status_t    status;
    } result_t;

endpackage

// ===== design/irdf_parse.sv =====
// Front part: per-byte header parser, classifier and configuration registers.
`include "assert_macros.svh"

module irdf_parse
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           data_byte,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [23:0]          cfg_data,
    output logic                 push,
    output irdf_pkg::result_t    result
);
    import irdf_pkg::*;

    logic [23:0] max_len_reg;
    logic [6:0]  video_type_reg;
    logic [6:0]  audio_type_reg;
    logic [3:0]  audio_skip_reg;

    logic [4:0]  header_pos_reg, header_pos_next;
    logic [23:0] length_shift_reg, length_shift_next;
    logic [23:0] bytes_left_reg, bytes_left_next;
    logic [7:0]  channel_reg, channel_next;
    logic [6:0]  type_reg, type_next;
    logic [31:0] stamp_shift_reg, stamp_shift_next;
    logic [31:0] last_stamp_reg, last_stamp_next;
    logic        stamp_held_reg, stamp_held_next;
    logic [3:0]  skip_left_reg, skip_left_next;
    logic        start_pending_reg, start_pending_next;

    logic [31:0] len_word;
    logic [23:0] bytes_dec;
    logic [4:0]  rtp_ofs;
    logic        is_video;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg    <= RST_MAX_LEN;
            video_type_reg <= RST_VIDEO_TYPE;
            audio_type_reg <= RST_AUDIO_TYPE;
            audio_skip_reg <= RST_AUDIO_SKIP;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MAX_LEN:    max_len_reg    <= cfg_data;
                REG_VIDEO_TYPE: video_type_reg <= cfg_data[6:0];
                REG_AUDIO_TYPE: audio_type_reg <= cfg_data[6:0];
                REG_AUDIO_SKIP: audio_skip_reg <= cfg_data[3:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_pos_reg    <= POS_HUNT;
            length_shift_reg  <= '0;
            bytes_left_reg    <= '0;
            channel_reg       <= '0;
            type_reg          <= '0;
            stamp_shift_reg   <= '0;
            last_stamp_reg    <= '0;
            stamp_held_reg    <= 1'b0;
            skip_left_reg     <= '0;
            start_pending_reg <= 1'b0;
        end
        else
        begin
            header_pos_reg    <= header_pos_next;
            length_shift_reg  <= length_shift_next;
            bytes_left_reg    <= bytes_left_next;
            channel_reg       <= channel_next;
            type_reg          <= type_next;
            stamp_shift_reg   <= stamp_shift_next;
            last_stamp_reg    <= last_stamp_next;
            stamp_held_reg    <= stamp_held_next;
            skip_left_reg     <= skip_left_next;
            start_pending_reg <= start_pending_next;
        end
    end

    // The four length bytes fully replace the word, so only three are kept.
    assign len_word  = {length_shift_reg, data_byte};
    assign bytes_dec = bytes_left_reg - {23'd0, (bytes_left_reg != '0)};
    assign rtp_ofs   = header_pos_reg - POS_RTP_FIRST;
    assign is_video  = (type_reg == video_type_reg);

    always_comb
    begin
        header_pos_next    = header_pos_reg;
        length_shift_next  = length_shift_reg;
        bytes_left_next    = bytes_left_reg;
        channel_next       = channel_reg;
        type_next          = type_reg;
        stamp_shift_next   = stamp_shift_reg;
        last_stamp_next    = last_stamp_reg;
        stamp_held_next    = stamp_held_reg;
        skip_left_next     = skip_left_reg;
        start_pending_next = start_pending_reg;
        push               = 1'b0;
        result             = '0;

        if (accept)
        begin
            priority if (header_pos_reg == POS_HUNT || header_pos_reg == POS_EXPECT)
            begin
                if (data_byte == SYNC_BYTE)
                begin
                    header_pos_next = POS_CHANNEL;
                end
                else if (header_pos_reg == POS_EXPECT)
                begin
                    header_pos_next    = POS_HUNT;
                    stamp_held_next    = 1'b0;
                    start_pending_next = 1'b0;
                    bytes_left_next    = '0;
                    push               = 1'b1;
                    result.status      = ST_REJECT;
                end
            end
            else if (header_pos_reg == POS_CHANNEL)
            begin
                channel_next    = data_byte;
                header_pos_next = header_pos_reg + 5'd1;
            end
            else if (header_pos_reg < POS_LEN_LAST)
            begin
                if (header_pos_reg >= POS_LEN_FIRST)
                begin
                    length_shift_next = {length_shift_reg[15:0], data_byte};
                end
                header_pos_next = header_pos_reg + 5'd1;
            end
            else if (header_pos_reg == POS_LEN_LAST)
            begin
                length_shift_next = len_word[23:0];
                if (len_word == '0 || len_word[31:24] != 8'd0 || len_word[23:0] > max_len_reg)
                begin
                    header_pos_next    = POS_HUNT;
                    stamp_held_next    = 1'b0;
                    start_pending_next = 1'b0;
                    bytes_left_next    = '0;
                    push               = 1'b1;
                    result.status      = ST_REJECT;
                end
                else
                begin
                    bytes_left_next = len_word[23:0];
                    if (len_word[23:0] < RTP_HDR_BYTES)
                    begin
                        header_pos_next   = POS_DROP;
                        push              = 1'b1;
                        result.channel_id = channel_reg;
                        result.status     = ST_SHORT;
                    end
                    else
                    begin
                        header_pos_next = POS_RTP_FIRST;
                    end
                end
            end
            else if (header_pos_reg <= POS_RTP_LAST)
            begin
                bytes_left_next = bytes_dec;
                if (rtp_ofs == RTP_TYPE_OFS)
                begin
                    type_next = data_byte[6:0];
                end
                if (rtp_ofs >= RTP_STAMP_FIRST_OFS && rtp_ofs <= RTP_STAMP_LAST_OFS)
                begin
                    stamp_shift_next = {stamp_shift_reg[23:0], data_byte};
                end
                if (header_pos_reg != POS_RTP_LAST)
                begin
                    header_pos_next = header_pos_reg + 5'd1;
                end
                else
                begin
                    // The timestamp is complete long before the last header byte.
                    if (is_video)
                    begin
                        if (!stamp_held_reg || stamp_shift_reg != last_stamp_reg)
                        begin
                            start_pending_next = 1'b1;
                        end
                        last_stamp_next = stamp_shift_reg;
                        stamp_held_next = 1'b1;
                        header_pos_next = POS_PAYLOAD;
                    end
                    else if (type_reg == audio_type_reg)
                    begin
                        skip_left_next  = audio_skip_reg;
                        header_pos_next = POS_PAYLOAD;
                    end
                    else
                    begin
                        header_pos_next = POS_DROP;
                    end
                    if (bytes_dec == '0)
                    begin
                        header_pos_next = POS_EXPECT;
                    end
                end
            end
            else if (header_pos_reg == POS_PAYLOAD || header_pos_reg == POS_DROP)
            begin
                if (bytes_left_reg == '0)
                begin
                    header_pos_next = POS_EXPECT;
                end
                else
                begin
                    bytes_left_next = bytes_dec;
                    if (bytes_dec == '0)
                    begin
                        header_pos_next = POS_EXPECT;
                    end
                    if (header_pos_reg == POS_PAYLOAD)
                    begin
                        if (is_video)
                        begin
                            start_pending_next  = 1'b0;
                            push                = 1'b1;
                            result.payload_byte = data_byte;
                            result.stream_kind  = KIND_VIDEO;
                            result.channel_id   = channel_reg;
                            result.frame_start  = start_pending_reg;
                            result.packet_last  = (bytes_dec == '0);
                            result.status       = ST_DATA;
                        end
                        else if (skip_left_reg != '0)
                        begin
                            skip_left_next = skip_left_reg - 4'd1;
                        end
                        else
                        begin
                            push                = 1'b1;
                            result.payload_byte = data_byte;
                            result.stream_kind  = KIND_AUDIO;
                            result.channel_id   = channel_reg;
                            result.packet_last  = (bytes_dec == '0);
                            result.status       = ST_DATA;
                        end
                    end
                end
            end
            else
            begin
                header_pos_next = POS_HUNT;
            end
        end
    end

    `ASSERT_CLK(a_reject_is_clean, push && result.status == ST_REJECT |-> result.channel_id == 8'd0 && result.payload_byte == 8'd0 && !stamp_held_next, "reject result carries data or keeps the held timestamp")
    `ASSERT_CLK(a_reject_hunts, push && result.status == ST_REJECT |=> header_pos_reg == POS_HUNT && bytes_left_reg == 24'd0, "parser did not return to hunting after a reject")
    `ASSERT_NEVER(a_push_only_on_accept, push && !accept, "result produced without an accepted byte")

endmodule

// ===== design/irdf_queue.sv =====
// Back part: short result queue that drives the output channel.
`include "assert_macros.svh"

module irdf_queue #(
    parameter int DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  irdf_pkg::result_t    push_item,
    output logic                 full,
    output logic                 out_valid,
    input  logic                 out_stall,
    output irdf_pkg::result_t    out_item
);
    import irdf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t           mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    `ASSERT_NEVER(a_no_overflow, push && full, "queue written while full")
    `ASSERT_CLK(a_count_drops_on_pop, pop && !push |=> count_reg == $past(count_reg) - 1'b1, "queue count did not fall after a pop")

endmodule

// ===== design/interleaved_rtp_deframer_unit.sv =====
// Top level of the interleaved RTP deframer: parser, result queue and port wiring.
//
//  channel | direction | handshake            | payload
//  input   | in        | in_valid / in_stall  | data_byte
//  output  | out       | out_valid / out_stall| payload_byte, stream_kind, channel_id,
//          |           |                      | frame_start, packet_last, status
//  config  | in        | cfg_write            | cfg_index, cfg_data
//
// One byte is taken per cycle while the queue is not full; the parser finishes each byte
// in the cycle it is accepted; its result reaches the output behind any earlier results.
// The result queue holds QUEUE_DEPTH transactions; in_stall rises only while it is full.
// Reset clears all parser state and loads the configuration defaults; no clearing pass.
module interleaved_rtp_deframer_unit #(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  payload_byte,
    output logic        stream_kind,
    output logic [7:0]  channel_id,
    output logic        frame_start,
    output logic        packet_last,
    output logic [1:0]  status,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import irdf_pkg::*;

    logic    queue_full;
    logic    accept;
    logic    push;
    result_t push_item;
    result_t out_item;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    irdf_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .result    (push_item)
    );

    irdf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    assign payload_byte = out_item.payload_byte;
    assign stream_kind  = out_item.stream_kind;
    assign channel_id   = out_item.channel_id;
    assign frame_start  = out_item.frame_start;
    assign packet_last  = out_item.packet_last;
    assign status       = out_item.status;

endmodule

// ===== sim/tb_interleaved_rtp_deframer_unit.sv =====
// Self-checking testbench for the interleaved RTP deframer: directed table, then random phases.
module tb_interleaved_rtp_deframer_unit;

    import irdf_pkg::*;

    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum logic {
        ROW_NOISE,
        ROW_PACKET
    } row_kind_t;

    // A noise row sends the chan field as one lone byte.
    typedef struct packed {
        row_kind_t   kind;
        logic [7:0]  chan;
        logic [31:0] len;
        logic [6:0]  pt;
        logic [31:0] stamp;
        logic        pinned;
        logic [7:0]  want_chan;
        status_t     want_status;
    } probe_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  payload_byte;
    logic        stream_kind;
    logic [7:0]  channel_id;
    logic        frame_start;
    logic        packet_last;
    logic [1:0]  status;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = REG_MAX_LEN;
    logic [23:0] cfg_data = 24'd0;

    // A typed expectation travels with the byte it belongs to.
    logic        pin_on = 1'b0;
    result_t     pin_res = '0;

    // Predictor copy of the deframer state and registers.
    logic [4:0]  hdr_pos = POS_HUNT;
    logic [31:0] len_acc = '0;
    logic [23:0] remain = '0;
    logic [7:0]  pkt_chan = '0;
    logic [6:0]  pkt_type = '0;
    logic [31:0] ts_acc = '0;
    logic [31:0] held_ts = '0;
    logic        ts_held = 1'b0;
    logic [3:0]  skip_cnt = '0;
    logic        fs_armed = 1'b0;
    logic [23:0] lim_len = RST_MAX_LEN;
    logic [6:0]  vid_pt = RST_VIDEO_TYPE;
    logic [6:0]  aud_pt = RST_AUDIO_TYPE;
    logic [3:0]  aud_skip_n = RST_AUDIO_SKIP;

    result_t     due_results[$];
    int          mismatches = 0;
    int          bytes_fed = 0;
    int          quiet_cycles = 0;
    bit          calm = 1'b0;
    probe_row_t  probe_rows[18];

    interleaved_rtp_deframer_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .payload_byte (payload_byte),
        .stream_kind  (stream_kind),
        .channel_id   (channel_id),
        .frame_start  (frame_start),
        .packet_last  (packet_last),
        .status       (status),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    // Losing sync also forgets the held video timestamp.
    function automatic result_t lose_sync();
        result_t r;
        r        = '0;
        r.status = ST_REJECT;
        hdr_pos  = POS_HUNT;
        ts_held  = 1'b0;
        fs_armed = 1'b0;
        remain   = '0;
        return r;
    endfunction

    function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
        logic [4:0]  pos0;
        logic [31:0] len;
        logic [4:0]  ofs;
        logic        last;
        r    = '0;
        pos0 = hdr_pos;
        if (pos0 == POS_HUNT || pos0 == POS_EXPECT)
        begin
            if (b == SYNC_BYTE)
            begin
                hdr_pos = POS_CHANNEL;
                return 1'b0;
            end
            if (pos0 == POS_HUNT)
                return 1'b0;
            r = lose_sync();
            return 1'b1;
        end
        if (pos0 == POS_CHANNEL)
        begin
            pkt_chan = b;
            hdr_pos  = pos0 + 5'd1;
            return 1'b0;
        end
        if (pos0 < POS_LEN_LAST)
        begin
            if (pos0 >= POS_LEN_FIRST)
                len_acc = {len_acc[23:0], b};
            hdr_pos = pos0 + 5'd1;
            return 1'b0;
        end
        if (pos0 == POS_LEN_LAST)
        begin
            len     = {len_acc[23:0], b};
            len_acc = len;
            if (len == 32'd0 || len > {8'd0, lim_len})
            begin
                r = lose_sync();
                return 1'b1;
            end
            remain = len[23:0];
            if (len < {8'd0, RTP_HDR_BYTES})
            begin
                hdr_pos      = POS_DROP;
                r.channel_id = pkt_chan;
                r.status     = ST_SHORT;
                return 1'b1;
            end
            hdr_pos = POS_RTP_FIRST;
            return 1'b0;
        end
        if (pos0 <= POS_RTP_LAST)
        begin
            ofs = pos0 - POS_RTP_FIRST;
            if (remain != 24'd0)
                remain = remain - 24'd1;
            if (ofs == RTP_TYPE_OFS)
                pkt_type = b[6:0];
            if (ofs >= RTP_STAMP_FIRST_OFS && ofs <= RTP_STAMP_LAST_OFS)
                ts_acc = {ts_acc[23:0], b};
            if (pos0 != POS_RTP_LAST)
            begin
                hdr_pos = pos0 + 5'd1;
                return 1'b0;
            end
            if (pkt_type == vid_pt)
            begin
                if (!ts_held || ts_acc != held_ts)
                    fs_armed = 1'b1;
                held_ts = ts_acc;
                ts_held = 1'b1;
                hdr_pos = POS_PAYLOAD;
            end
            else if (pkt_type == aud_pt)
            begin
                skip_cnt = aud_skip_n;
                hdr_pos  = POS_PAYLOAD;
            end
            else
                hdr_pos = POS_DROP;
            if (remain == 24'd0)
                hdr_pos = POS_EXPECT;
            return 1'b0;
        end
        if (pos0 == POS_PAYLOAD || pos0 == POS_DROP)
        begin
            if (remain == 24'd0)
            begin
                hdr_pos = POS_EXPECT;
                return 1'b0;
            end
            remain = remain - 24'd1;
            last   = (remain == 24'd0);
            if (last)
                hdr_pos = POS_EXPECT;
            if (pos0 == POS_DROP)
                return 1'b0;
            if (pkt_type == vid_pt)
            begin
                r = '{b, KIND_VIDEO, pkt_chan, fs_armed, last, ST_DATA};
                fs_armed = 1'b0;
                return 1'b1;
            end
            if (skip_cnt != 4'd0)
            begin
                skip_cnt = skip_cnt - 4'd1;
                return 1'b0;
            end
            r = '{b, KIND_AUDIO, pkt_chan, 1'b0, last, ST_DATA};
            return 1'b1;
        end
        hdr_pos = POS_HUNT;
        return 1'b0;
    endfunction

    // Follows every transaction on the three ports: predicts, then checks.
    always @(posedge clk)
    begin : track
        result_t got;
        result_t want;
        result_t guess;
        bit      made;
        if (rst_n)
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_MAX_LEN:    lim_len    = cfg_data;
                    REG_VIDEO_TYPE: vid_pt     = cfg_data[6:0];
                    REG_AUDIO_TYPE: aud_pt     = cfg_data[6:0];
                    REG_AUDIO_SKIP: aud_skip_n = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                made = deframe_byte(data_byte, guess);
                if (pin_on)
                    due_results.push_back(pin_res);
                else if (made)
                    due_results.push_back(guess);
            end
            if (out_valid && !out_stall)
            begin
                got = {payload_byte, stream_kind, channel_id, frame_start, packet_last, status};
                if (due_results.size() == 0)
                begin
                    $display("%0t: unexpected result %02h kind %0d chan %02h fs %0d last %0d st %0d",
                             $time, got.payload_byte, got.stream_kind, got.channel_id,
                             got.frame_start, got.packet_last, got.status);
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    // Fields are byte/kind/chan/fs/last/st.
                    if (got !== want)
                    begin
                        $display({"%0t: mismatch expected %02h/%0d/%02h/%0d/%0d/%0d",
                                  " got %02h/%0d/%02h/%0d/%0d/%0d"},
                                 $time, want.payload_byte, want.stream_kind, want.channel_id,
                                 want.frame_start, want.packet_last, want.status,
                                 got.payload_byte, got.stream_kind, got.channel_id,
                                 got.frame_start, got.packet_last, got.status);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
    end

    // Receiver back-pressure: short stalls mostly, a few long ones, and calm stretches.
    initial
    begin
        int run;
        int hold;
        forever
        begin
            run  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
            hold = ($urandom_range(0, 11) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            out_stall <= 1'b0;
            repeat (run) @(posedge clk);
            out_stall <= 1'b1;
            repeat (hold) @(posedge clk);
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic pin, input result_t want);
        int gap;
        int roll;
        gap = 0;
        if (!calm)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
                gap = 0;
            else if (roll < 88)
                gap = $urandom_range(1, 3);
            else if (roll < 98)
                gap = $urandom_range(4, 10);
            else
                gap = $urandom_range(15, 40);
        end
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        pin_on    <= pin;
        pin_res   <= want;
        do @(posedge clk); while (in_stall !== 1'b0);
        bytes_fed++;
    endtask

    // Prefix, then body bytes: RTP header (type, timestamp) followed by random payload.
    task automatic send_packet(input logic [7:0] chan, input logic [31:0] len,
                               input logic [6:0] pt, input logic [31:0] stamp,
                               input int body, input logic pin, input result_t want);
        logic [7:0] b;
        int         i;
        push_byte(SYNC_BYTE, 1'b0, '0);
        push_byte(chan, 1'b0, '0);
        push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        push_byte(len[31:24], 1'b0, '0);
        push_byte(len[23:16], 1'b0, '0);
        push_byte(len[15:8], 1'b0, '0);
        push_byte(len[7:0], pin, want);
        for (i = 0; i < body; i++)
        begin
            case (i)
                1:       b = {1'($urandom_range(0, 1)), pt};
                4:       b = stamp[31:24];
                5:       b = stamp[23:16];
                6:       b = stamp[15:8];
                7:       b = stamp[7:0];
                default: b = 8'($urandom_range(0, 255));
            endcase
            push_byte(b, 1'b0, '0);
        end
    endtask

    task automatic reprogram(input logic [23:0] lim, input logic [6:0] vpt,
                             input logic [6:0] apt, input logic [3:0] skip);
        in_valid <= 1'b0;
        // Stepping the clock lets the tracker log the result of the last accepted byte.
        @(posedge clk);
        while (due_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_MAX_LEN;
        cfg_data  <= lim;
        @(posedge clk);
        cfg_index <= REG_VIDEO_TYPE;
        cfg_data  <= {17'd0, vpt};
        @(posedge clk);
        cfg_index <= REG_AUDIO_TYPE;
        cfg_data  <= {17'd0, apt};
        @(posedge clk);
        cfg_index <= REG_AUDIO_SKIP;
        cfg_data  <= {20'd0, skip};
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Mostly well-formed packets with random content; the rest is noise and bad headers.
    task automatic run_phase(input int budget);
        int          stop;
        int          pick;
        int          cap;
        int          extra;
        int          n;
        logic [31:0] len;
        logic [31:0] stamp;
        logic [6:0]  pt;
        logic [7:0]  b;
        stop  = bytes_fed + budget;
        stamp = $urandom;
        while (bytes_fed < stop)
        begin
            calm = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                cap = (lim_len > 24'd1212) ? 1200 : int'(lim_len) - 12;
                if ($urandom_range(0, 32) == 0)
                    extra = $urandom_range(0, cap);
                else
                    extra = $urandom_range(0, (cap < 30) ? cap : 30);
                len = 32'(12 + extra);
                n   = $urandom_range(0, 99);
                pt  = (n < 45) ? vid_pt : (n < 80) ? aud_pt : 7'($urandom_range(0, 127));
                if ($urandom_range(0, 1) == 0)
                    stamp = $urandom;
                send_packet(8'($urandom_range(0, 255)), len, pt, stamp, int'(len), 1'b0, '0);
            end
            else if (pick < 84)
            begin
                // Noise never carries the sync byte, so it cannot open a bogus prefix.
                n = $urandom_range(1, 4);
                repeat (n)
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b == SYNC_BYTE)
                        b = ~b;
                    push_byte(b, 1'b0, '0);
                end
            end
            else
            begin
                n = $urandom_range(0, 2);
                if (n == 0)
                    len = 32'd0;
                else if (n == 1)
                    len = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF
                                                      : {8'd0, lim_len} + 32'($urandom_range(1, 3));
                else
                    len = 32'($urandom_range(1, 11));
                send_packet(8'($urandom_range(0, 255)), len, 7'd0, 32'd0,
                            (n == 2) ? int'(len) : 0, 1'b0, '0);
            end
        end
        calm = 1'b0;
    endtask

    initial
    begin
        probe_row_t row;
        result_t    want;
        probe_rows = '{
            '{ROW_NOISE,  8'h00, 32'd0,        7'd0,   32'd0,        1'b0, 8'h00, ST_DATA},
            '{ROW_NOISE,  8'hFF, 32'd0,        7'd0,   32'd0,        1'b0, 8'h00, ST_DATA},
            '{ROW_PACKET, 8'hFF, 32'd0,        7'd0,   32'd0,        1'b1, 8'h00, ST_REJECT},
            '{ROW_PACKET, 8'h00, 32'd2764801,  7'd0,   32'd0,        1'b1, 8'h00, ST_REJECT},
            '{ROW_PACKET, 8'h80, 32'hFFFFFFFF, 7'd0,   32'd0,        1'b1, 8'h00, ST_REJECT},
            '{ROW_PACKET, 8'h07, 32'd1,        7'd0,   32'd0,        1'b1, 8'h07, ST_SHORT},
            '{ROW_PACKET, 8'h12, 32'd11,       7'd0,   32'd0,        1'b1, 8'h12, ST_SHORT},
            '{ROW_PACKET, 8'hFF, 32'd12,       7'd96,  32'd0,        1'b0, 8'h00, ST_DATA},
            '{ROW_PACKET, 8'h01, 32'd16,       7'd96,  32'd0,        1'b0, 8'h00, ST_DATA},
            '{ROW_PACKET, 8'h01, 32'd14,       7'd96,  32'd0,        1'b0, 8'h00, ST_DATA},
            '{ROW_PACKET, 8'h02, 32'd13,       7'd96,  32'hFFFFFFFF, 1'b0, 8'h00, ST_DATA},
            '{ROW_PACKET, 8'h03, 32'd16,       7'd97,  32'd5,        1'b0, 8'h00, ST_DATA},
            '{ROW_PACKET, 8'h03, 32'd20,       7'd97,  32'd5,        1'b0, 8'h00, ST_DATA},
            '{ROW_PACKET, 8'h04, 32'd15,       7'd127, 32'd0,        1'b0, 8'h00, ST_DATA},
            '{ROW_PACKET, 8'h05, 32'd13,       7'd0,   32'd0,        1'b0, 8'h00, ST_DATA},
            '{ROW_NOISE,  8'h25, 32'd0,        7'd0,   32'd0,        1'b1, 8'h00, ST_REJECT},
            '{ROW_NOISE,  8'h00, 32'd0,        7'd0,   32'd0,        1'b0, 8'h00, ST_DATA},
            '{ROW_PACKET, 8'hFE, 32'd18,       7'd96,  32'hFFFFFFFF, 1'b0, 8'h00, ST_DATA}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probe_rows[i])
        begin
            row  = probe_rows[i];
            want = '{8'h00, KIND_VIDEO, row.want_chan, 1'b0, 1'b0, row.want_status};
            if (row.kind == ROW_NOISE)
                push_byte(row.chan, row.pinned, want);
            else
                send_packet(row.chan, row.len, row.pt, row.stamp,
                            (row.pinned && row.want_status == ST_REJECT) ? 0 : int'(row.len),
                            row.pinned, want);
        end

        reprogram(24'hFF_FFFF, 7'd0, 7'd127, 4'd0);
        run_phase(225);
        // Only empty packets fit under the smallest limit.
        reprogram(24'd12, 7'd96, 7'd97, 4'd15);
        run_phase(225);
        // Equal types: audio-typed packets are handled as video.
        reprogram(24'd40, 7'd5, 7'd5, 4'd7);
        run_phase(225);
        reprogram(24'd200, 7'd127, 7'd0, 4'd15);
        run_phase(225);
        reprogram(24'($urandom_range(12, 100)), 7'($urandom_range(0, 127)),
                  7'($urandom_range(0, 127)), 4'($urandom_range(0, 15)));
        run_phase(225);
        reprogram(RST_MAX_LEN, RST_VIDEO_TYPE, RST_AUDIO_TYPE, RST_AUDIO_SKIP);
        run_phase(225);

        in_valid <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/irdf_pkg.sv
design/irdf_parse.sv
design/irdf_queue.sv
design/interleaved_rtp_deframer_unit.sv
sim/tb_interleaved_rtp_deframer_unit.sv
